>>> sv/elfchk_pkg.sv
// elfchk_pkg: item types, status codes and accumulator record for the elf64 image checker
// used by every module of the checker; depends on nothing
package elfchk_pkg;

  localparam logic [7:0]  MagicB0      = 8'h7f;
  localparam logic [7:0]  MagicB1      = 8'h45;
  localparam logic [7:0]  MagicB2      = 8'h4c;
  localparam logic [7:0]  MagicB3      = 8'h46;
  localparam logic [7:0]  Class64      = 8'd2;
  localparam logic [7:0]  DataLsb      = 8'd1;
  localparam logic [7:0]  IdentVersion = 8'd1;
  localparam logic [15:0] MachineX8664 = 16'd62;
  localparam logic [31:0] TypeExec     = 32'd2;
  localparam logic [31:0] TypeDyn      = 32'd3;
  localparam logic [31:0] SegLoad      = 32'd1;
  localparam logic [15:0] EhdrSize     = 16'd64;
  localparam logic [15:0] PhdrSize     = 16'd56;
  localparam logic [63:0] MinImageSize = 64'd64;

  typedef enum logic [0:0] {
    CMD_FILE_HDR = 1'b0,
    CMD_PROG_HDR = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    ST_PENDING  = 4'd0,
    ST_OK       = 4'd1,
    ST_SMALL    = 4'd2,
    ST_MAGIC    = 4'd3,
    ST_CLASS    = 4'd4,
    ST_MACHINE  = 4'd5,
    ST_TYPE     = 4'd6,
    ST_HEADER   = 4'd7,
    ST_TABLE    = 4'd8,
    ST_SEGSIZE  = 4'd9,
    ST_SEGFILE  = 4'd10,
    ST_SEGMEM   = 4'd11,
    ST_NOLOAD   = 4'd12,
    ST_SEQUENCE = 4'd13
  } status_e;

  typedef struct packed {
    logic [0:0]  command;
    logic [55:0] ident_word;
    logic [31:0] type_code;
    logic [15:0] machine_code;
    logic [15:0] header_size;
    logic [15:0] table_entry_size;
    logic [15:0] table_count;
    logic [63:0] file_offset;
    logic [63:0] address;
    logic [63:0] seg_file_size;
    logic [63:0] seg_mem_size;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic        done_res;
    logic [63:0] entry_point;
    logic [15:0] headers_total;
    logic [15:0] loads_seen;
    logic [63:0] lowest_vaddr;
    logic [63:0] highest_vaddr_end;
    logic [63:0] lowest_offset;
    logic [63:0] highest_offset_end;
  } out_item_t;

  typedef struct packed {
    logic [15:0] load_tally;
    logic [63:0] min_addr;
    logic [63:0] max_addr_end;
    logic [63:0] min_off;
    logic [63:0] max_off_end;
  } acc_t;

  localparam acc_t AccReset = '{
    load_tally:   16'd0,
    min_addr:     '1,
    max_addr_end: 64'd0,
    min_off:      '1,
    max_off_end:  64'd0
  };

endpackage

>>> sv/elfchk_hdr_chk.sv
// elfchk_hdr_chk: combinational checks of one file header item
// depends on elfchk_pkg
module elfchk_hdr_chk (
  input  elfchk_pkg::in_item_t item_i,
  input  logic [63:0]          image_size_i,
  output elfchk_pkg::status_e  err_o
);
  import elfchk_pkg::*;

  logic [21:0] table_bytes;
  logic [64:0] table_end;
  logic        magic_ok;
  logic        class_ok;
  logic        type_ok;
  logic        sizes_ok;

  assign table_bytes = {6'd0, item_i.table_count} * 22'(PhdrSize);
  assign table_end   = {1'b0, item_i.file_offset} + {43'd0, table_bytes};

  assign magic_ok = (item_i.ident_word[7:0] == MagicB0) && (item_i.ident_word[15:8] == MagicB1)
                 && (item_i.ident_word[23:16] == MagicB2)
                 && (item_i.ident_word[31:24] == MagicB3);
  assign class_ok = (item_i.ident_word[39:32] == Class64) && (item_i.ident_word[47:40] == DataLsb)
                 && (item_i.ident_word[55:48] == IdentVersion);
  assign type_ok  = (item_i.type_code == TypeExec) || (item_i.type_code == TypeDyn);
  assign sizes_ok = (item_i.header_size == EhdrSize) && (item_i.table_entry_size == PhdrSize)
                 && (item_i.table_count != 16'd0);

  always_comb begin
    if (image_size_i < MinImageSize) begin
      err_o = ST_SMALL;
    end else if (!magic_ok) begin
      err_o = ST_MAGIC;
    end else if (!class_ok) begin
      err_o = ST_CLASS;
    end else if (item_i.machine_code != MachineX8664) begin
      err_o = ST_MACHINE;
    end else if (!type_ok) begin
      err_o = ST_TYPE;
    end else if (!sizes_ok) begin
      err_o = ST_HEADER;
    end else if (table_end[64] || (table_end[63:0] > image_size_i)) begin
      err_o = ST_TABLE;
    end else begin
      err_o = ST_PENDING;
    end
  end

endmodule

>>> sv/elfchk_seg_chk.sv
// elfchk_seg_chk: checks one program header item and folds a good load segment
// into the running address and offset bounds; depends on elfchk_pkg
module elfchk_seg_chk (
  input  elfchk_pkg::in_item_t item_i,
  input  logic [63:0]          image_size_i,
  input  elfchk_pkg::acc_t     acc_i,
  output elfchk_pkg::status_e  err_o,
  output elfchk_pkg::acc_t     acc_o
);
  import elfchk_pkg::*;

  logic [64:0] file_end;
  logic [64:0] mem_end;
  logic        is_load;

  assign is_load  = (item_i.type_code == SegLoad);
  assign file_end = {1'b0, item_i.file_offset} + {1'b0, item_i.seg_file_size};
  assign mem_end  = {1'b0, item_i.address} + {1'b0, item_i.seg_mem_size};

  always_comb begin
    if (!is_load) begin
      err_o = ST_PENDING;
    end else if (item_i.seg_file_size > item_i.seg_mem_size) begin
      err_o = ST_SEGSIZE;
    end else if (file_end[64] || (file_end[63:0] > image_size_i)) begin
      err_o = ST_SEGFILE;
    end else if (mem_end[64]) begin
      err_o = ST_SEGMEM;
    end else begin
      err_o = ST_PENDING;
    end
  end

  always_comb begin
    acc_o = acc_i;
    if (is_load && (err_o == ST_PENDING)) begin
      acc_o.load_tally = acc_i.load_tally + 16'd1;
      if (item_i.address < acc_i.min_addr) begin
        acc_o.min_addr = item_i.address;
      end
      if (mem_end[63:0] > acc_i.max_addr_end) begin
        acc_o.max_addr_end = mem_end[63:0];
      end
      if (item_i.file_offset < acc_i.min_off) begin
        acc_o.min_off = item_i.file_offset;
      end
      if (file_end[63:0] > acc_i.max_off_end) begin
        acc_o.max_off_end = file_end[63:0];
      end
    end
  end

endmodule

>>> sv/elf64_image_header_checker_top.sv
// elf64_image_header_checker_top: input register, image state, check logic and result register
// depends on elfchk_pkg, elfchk_hdr_chk and elfchk_seg_chk
//
// usage: write the image byte length through cfg_we_i / cfg_wdata_i while idle, then
// send one file header item followed by one item per program header on the in channel.
// every accepted item yields exactly one result item on the out channel, carrying the
// status, a done flag and the entry point, header count and load segment bounds so far.
// an item is taken at a clock edge with valid high and stall low on its channel.
// an accepted item sits in the input register, is checked there once the result register is free,
// and its result is registered in the result register, from which it can then be taken.
// throughput: one item per cycle while the out channel does not stall; the critical path is the
// 64-bit end-address add feeding the image-size compare and the min/max updates.
// a stalled result holds; the input register still accepts one more item, after which
// in_stall_o rises until the result is taken.
// reset clears the image state, the image size and both valid flags; in_stall_o is low out of
// reset, so the block can take an item as soon as reset is released.
module elf64_image_header_checker_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [63:0]           cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  elfchk_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output elfchk_pkg::out_item_t out_item_o
);
  import elfchk_pkg::*;

  logic [63:0] image_size_q;
  in_item_t    in_q;
  logic        in_vld_q, in_vld_d;
  out_item_t   out_q, out_d;
  logic        out_vld_q, out_vld_d;
  logic        out_free;
  logic        fire;
  logic        in_accept;

  logic        busy_q, busy_d;
  logic [15:0] remaining_q, remaining_d;
  logic [63:0] entry_q, entry_d;
  logic [15:0] count_q, count_d;
  acc_t        acc_q, acc_d;

  status_e     hdr_err;
  status_e     seg_err;
  acc_t        seg_acc;
  status_e     status;
  logic        done;

  elfchk_hdr_chk u_hdr_chk (
    .item_i       (in_q),
    .image_size_i (image_size_q),
    .err_o        (hdr_err)
  );

  elfchk_seg_chk u_seg_chk (
    .item_i       (in_q),
    .image_size_i (image_size_q),
    .acc_i        (acc_q),
    .err_o        (seg_err),
    .acc_o        (seg_acc)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_accept || (in_vld_q && !fire);
  assign out_vld_d  = fire || (out_vld_q && out_stall_i);

  always_comb begin
    busy_d      = busy_q;
    remaining_d = remaining_q;
    entry_d     = entry_q;
    count_d     = count_q;
    acc_d       = acc_q;
    status      = ST_PENDING;
    done        = 1'b0;
    if (in_q.command == CMD_FILE_HDR) begin
      if (busy_q) begin
        status      = ST_SEQUENCE;
        done        = 1'b1;
        busy_d      = 1'b0;
        remaining_d = 16'd0;
      end else begin
        acc_d   = AccReset;
        entry_d = 64'd0;
        count_d = 16'd0;
        if (hdr_err != ST_PENDING) begin
          status = hdr_err;
          done   = 1'b1;
        end else begin
          entry_d     = in_q.address;
          count_d     = in_q.table_count;
          remaining_d = in_q.table_count;
          busy_d      = 1'b1;
        end
      end
    end else begin
      if (!busy_q) begin
        status = ST_SEQUENCE;
        done   = 1'b1;
      end else if (seg_err != ST_PENDING) begin
        status      = seg_err;
        done        = 1'b1;
        busy_d      = 1'b0;
        remaining_d = 16'd0;
      end else begin
        acc_d = seg_acc;
        if (remaining_q <= 16'd1) begin
          remaining_d = 16'd0;
          busy_d      = 1'b0;
          done        = 1'b1;
          status      = (seg_acc.load_tally == 16'd0) ? ST_NOLOAD : ST_OK;
        end else begin
          remaining_d = remaining_q - 16'd1;
        end
      end
    end
  end

  always_comb begin
    out_d.status             = status;
    out_d.done_res           = done;
    out_d.entry_point        = entry_d;
    out_d.headers_total      = count_d;
    out_d.loads_seen         = acc_d.load_tally;
    out_d.lowest_vaddr       = acc_d.min_addr;
    out_d.highest_vaddr_end  = acc_d.max_addr_end;
    out_d.lowest_offset      = acc_d.min_off;
    out_d.highest_offset_end = acc_d.max_off_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q <= 64'd0;
      in_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      busy_q       <= 1'b0;
      remaining_q  <= 16'd0;
      entry_q      <= 64'd0;
      count_q      <= 16'd0;
      acc_q        <= AccReset;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        image_size_q <= cfg_wdata_i;
      end
      if (fire) begin
        busy_q      <= busy_d;
        remaining_q <= remaining_d;
        entry_q     <= entry_d;
        count_q     <= count_d;
        acc_q       <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_item_i;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

>>> dv/elfchk_tb_pkg.sv
`timescale 1ns / 1ps
// elfchk_tb_pkg: image verdict scoreboard for the elf64 image checker testbench
// predicts one result per accepted item and checks results in order; depends on elfchk_pkg
package elfchk_tb_pkg;
  import elfchk_pkg::*;

  class image_verdict_scoreboard;
    logic [63:0] image_bytes;
    bit          busy;
    logic [15:0] segs_left;
    logic [63:0] entry_seen;
    logic [15:0] count_seen;
    acc_t        acc;
    out_item_t   verdict_q[$];
    int          mismatches;

    function new();
      image_bytes = '0;
      busy = 1'b0;
      segs_left = '0;
      mismatches = 0;
      clear_report();
    endfunction

    function void clear_report();
      entry_seen = '0;
      count_seen = '0;
      acc = AccReset;
    endfunction

    function status_e header_fault(in_item_t it);
      logic [64:0] tend;
      if (image_bytes < MinImageSize) return ST_SMALL;
      if (it.ident_word[7:0] != MagicB0 || it.ident_word[15:8] != MagicB1 ||
          it.ident_word[23:16] != MagicB2 || it.ident_word[31:24] != MagicB3) return ST_MAGIC;
      if (it.ident_word[39:32] != Class64 || it.ident_word[47:40] != DataLsb ||
          it.ident_word[55:48] != IdentVersion) return ST_CLASS;
      if (it.machine_code != MachineX8664) return ST_MACHINE;
      if (it.type_code != TypeExec && it.type_code != TypeDyn) return ST_TYPE;
      if (it.header_size != EhdrSize || it.table_entry_size != PhdrSize ||
          it.table_count == 16'd0) return ST_HEADER;
      tend = {1'b0, it.file_offset} + {49'd0, it.table_count} * 65'd56;
      if (tend[64] || tend[63:0] > image_bytes) return ST_TABLE;
      return ST_PENDING;
    endfunction

    // only load segments are checked and folded into the bounds
    function status_e segment_fault(in_item_t it);
      logic [64:0] fend;
      logic [64:0] mend;
      if (it.type_code != SegLoad) return ST_PENDING;
      if (it.seg_file_size > it.seg_mem_size) return ST_SEGSIZE;
      fend = {1'b0, it.file_offset} + {1'b0, it.seg_file_size};
      if (fend[64] || fend[63:0] > image_bytes) return ST_SEGFILE;
      mend = {1'b0, it.address} + {1'b0, it.seg_mem_size};
      if (mend[64]) return ST_SEGMEM;
      if (it.address < acc.min_addr) acc.min_addr = it.address;
      if (mend[63:0] > acc.max_addr_end) acc.max_addr_end = mend[63:0];
      if (it.file_offset < acc.min_off) acc.min_off = it.file_offset;
      if (fend[63:0] > acc.max_off_end) acc.max_off_end = fend[63:0];
      acc.load_tally = acc.load_tally + 16'd1;
      return ST_PENDING;
    endfunction

    function out_item_t predict_verdict(in_item_t it);
      out_item_t v;
      status_e   fault;
      v = '0;
      v.status = ST_PENDING;
      v.done_res = 1'b0;
      if (it.command == CMD_FILE_HDR) begin
        if (busy) begin
          v.status = ST_SEQUENCE;
          v.done_res = 1'b1;
          busy = 1'b0;
          segs_left = '0;
        end else begin
          clear_report();
          fault = header_fault(it);
          if (fault != ST_PENDING) begin
            v.status = fault;
            v.done_res = 1'b1;
          end else begin
            entry_seen = it.address;
            count_seen = it.table_count;
            segs_left = it.table_count;
            busy = 1'b1;
          end
        end
      end else if (!busy) begin
        v.status = ST_SEQUENCE;
        v.done_res = 1'b1;
      end else begin
        fault = segment_fault(it);
        if (fault != ST_PENDING) begin
          v.status = fault;
          v.done_res = 1'b1;
          busy = 1'b0;
          segs_left = '0;
        end else if (segs_left <= 16'd1) begin
          segs_left = '0;
          busy = 1'b0;
          v.done_res = 1'b1;
          v.status = (acc.load_tally == 16'd0) ? ST_NOLOAD : ST_OK;
        end else begin
          segs_left = segs_left - 16'd1;
        end
      end
      v.entry_point = entry_seen;
      v.headers_total = count_seen;
      v.loads_seen = acc.load_tally;
      v.lowest_vaddr = acc.min_addr;
      v.highest_vaddr_end = acc.max_addr_end;
      v.lowest_offset = acc.min_off;
      v.highest_offset_end = acc.max_off_end;
      return v;
    endfunction

    function void note_item(in_item_t it);
      verdict_q.push_back(predict_verdict(it));
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (verdict_q.size() == 0) begin
        mismatches++;
        $error("result item with no item waiting");
        return;
      end
      want = verdict_q.pop_front();
      check_field("status", 64'(want.status), 64'(got.status));
      check_field("done_res", 64'(want.done_res), 64'(got.done_res));
      check_field("entry_point", want.entry_point, got.entry_point);
      check_field("headers_total", 64'(want.headers_total), 64'(got.headers_total));
      check_field("loads_seen", 64'(want.loads_seen), 64'(got.loads_seen));
      check_field("lowest_vaddr", want.lowest_vaddr, got.lowest_vaddr);
      check_field("highest_vaddr_end", want.highest_vaddr_end, got.highest_vaddr_end);
      check_field("lowest_offset", want.lowest_offset, got.lowest_offset);
      check_field("highest_offset_end", want.highest_offset_end, got.highest_offset_end);
    endfunction
  endclass

endpackage

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: directed and random image streams for elf64_image_header_checker_top with random
// idling on both channels and one long output hold; depends on elfchk_pkg and elfchk_tb_pkg
module tb_top;
  import elfchk_pkg::*;
  import elfchk_tb_pkg::*;

  localparam int          CycleLimit = 500000;
  localparam logic [63:0] AllOnes    = '1;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic [63:0] cfg_wdata = '0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  bit idling;
  bit hold_request;
  int items_sent;
  int cycles;
  image_verdict_scoreboard sb;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  elf64_image_header_checker_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_upto(logic [63:0] max);
    logic [63:0] r;
    r = rand64();
    case ($urandom_range(0, 3))
      0: r = r & 64'hffff;
      1: r = max;
      default: ;
    endcase
    if (max == AllOnes) return r;
    return r % (max + 64'd1);
  endfunction

  function automatic in_item_t noise_item();
    logic [415:0] bits;
    for (int w = 0; w < 13; w++) bits[w*32 +: 32] = $urandom;
    return in_item_t'(bits[$bits(in_item_t)-1:0]);
  endfunction

  function automatic in_item_t file_header(logic [15:0] count, logic [63:0] offset,
                                           logic [63:0] entry);
    in_item_t it;
    it = noise_item();
    it.command = CMD_FILE_HDR;
    it.ident_word = {IdentVersion, DataLsb, Class64, MagicB3, MagicB2, MagicB1, MagicB0};
    it.type_code = $urandom_range(0, 1) ? TypeExec : TypeDyn;
    it.machine_code = MachineX8664;
    it.header_size = EhdrSize;
    it.table_entry_size = PhdrSize;
    it.table_count = count;
    it.file_offset = offset;
    it.address = entry;
    return it;
  endfunction

  function automatic in_item_t prog_header(logic [31:0] kind, logic [63:0] offset,
                                           logic [63:0] vaddr, logic [63:0] fsize,
                                           logic [63:0] msize);
    in_item_t it;
    it = noise_item();
    it.command = CMD_PROG_HDR;
    it.type_code = kind;
    it.file_offset = offset;
    it.address = vaddr;
    it.seg_file_size = fsize;
    it.seg_mem_size = msize;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_image_size(logic [63:0] size);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.image_bytes = size;
  endtask

  task automatic run_image(logic [63:0] limit);
    in_item_t    it;
    logic [15:0] count;
    logic [63:0] tbytes, off, va, fsz, msz;
    logic [31:0] kind;
    int          fault;
    int          r;
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 3)) send_item(noise_item());
      return;
    end
    if ($urandom_range(0, 9) == 0) count = 16'($urandom_range(7, 40));
    else count = 16'($urandom_range(1, 6));
    tbytes = {48'd0, count} * 64'd56;
    if (tbytes > limit) begin
      count = (limit / 64'd56 == 64'd0) ? 16'd1 : 16'(limit / 64'd56);
      tbytes = {48'd0, count} * 64'd56;
    end
    off = (tbytes <= limit) ? rand_upto(limit - tbytes) : 64'd0;
    it = file_header(count, off, rand64());
    fault = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 0;
    case (fault)
      1: it.ident_word ^= 56'd1 << $urandom_range(0, 31);
      2: it.ident_word ^= 56'd1 << $urandom_range(32, 55);
      3: it.machine_code ^= 16'd1 << $urandom_range(0, 15);
      4: begin
        it.type_code = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 7);
        if (it.type_code == TypeExec || it.type_code == TypeDyn) it.type_code ^= 32'h8000_0000;
      end
      5: case ($urandom_range(0, 2))
        0: it.header_size ^= 16'd1 << $urandom_range(0, 15);
        1: it.table_entry_size ^= 16'd1 << $urandom_range(0, 15);
        default: it.table_count = 16'd0;
      endcase
      6: it.file_offset = $urandom_range(0, 1) ? (AllOnes - $urandom_range(0, 55)) : limit;
      default: ;
    endcase
    send_item(it);
    if (fault != 0) return;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send_item(file_header(16'd1, 64'd0, rand64()));
        return;
      end
      if (r < 3) begin
        send_item(noise_item());
        return;
      end
      off = rand_upto(limit);
      fsz = rand_upto(limit - off);
      msz = fsz + rand_upto(AllOnes - fsz);
      va = rand_upto(AllOnes - msz);
      if ($urandom_range(0, 9) < 7) begin
        kind = SegLoad;
      end else begin
        kind = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 8);
        if (kind == SegLoad) kind = 32'd0;
      end
      it = prog_header(kind, off, va, fsz, msz);
      if (r < 6) begin
        it.type_code = SegLoad;
        case ($urandom_range(0, 2))
          0: begin
            it.seg_file_size = (fsz == 64'd0) ? 64'd1 : fsz;
            it.seg_mem_size = rand_upto(it.seg_file_size - 64'd1);
          end
          1: begin
            if ($urandom_range(0, 1)) begin
              it.file_offset = AllOnes - $urandom_range(0, 7);
              it.seg_file_size = 64'($urandom_range(8, 4096));
            end else begin
              it.file_offset = limit;
              it.seg_file_size = 64'($urandom_range(1, 64));
            end
            it.seg_mem_size = it.seg_file_size;
          end
          default: begin
            it.file_offset = 64'd0;
            it.seg_file_size = 64'd0;
            it.address = AllOnes - $urandom_range(0, 15);
            it.seg_mem_size = 64'($urandom_range(16, 4096));
          end
        endcase
        send_item(it);
        return;
      end
      send_item(it);
    end
  endtask

  task automatic run_phase(logic [63:0] size, int quota, bit gaps);
    int start;
    set_image_size(size);
    idling = gaps;
    start = items_sent;
    while (items_sent - start < quota) run_image(size);
  endtask

  initial begin : watchdog
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : receiver
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) sb.check_result(out_item);
      if (stall_left > 0) stall_left--;
      else if (hold_request && !hold_done) begin
        stall_left = 300;
        hold_done = 1'b1;
      end else if (idling && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 11);
      out_stall <= (stall_left > 0);
    end
  end

  initial begin : stimulus
    in_item_t it;
    sb = new();
    idling = 1'b1;
    hold_request = 1'b0;
    items_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // image size still zero from reset
    send_item(prog_header(SegLoad, 64'd0, 64'd0, 64'd0, 64'd0));
    send_item(file_header(16'd1, 64'd8, 64'h40_1000));
    set_image_size(64'd63);
    send_item(file_header(16'd1, 64'd0, 64'h40_1000));
    set_image_size(64'd64);
    send_item(file_header(16'd1, 64'd8, 64'h40_1000));
    send_item(prog_header(SegLoad, 64'd0, 64'h40_0000, 64'd64, 64'd64));

    set_image_size(AllOnes);
    it = file_header(16'd1, 64'd64, 64'd0);
    it.ident_word[15:8] = 8'h65;
    send_item(it);
    it = file_header(16'd1, 64'd64, 64'd0);
    it.ident_word[39:32] = 8'd1;
    send_item(it);
    it = file_header(16'd1, 64'd64, 64'd0);
    it.machine_code = 16'd0;
    send_item(it);
    it = file_header(16'd1, 64'd64, 64'd0);
    it.type_code = 32'hffff_0002;
    send_item(it);
    it = file_header(16'd1, 64'd64, 64'd0);
    it.header_size = 16'd63;
    send_item(it);
    it = file_header(16'd1, 64'd64, 64'd0);
    it.table_entry_size = 16'hffff;
    send_item(it);
    send_item(file_header(16'd0, 64'd64, 64'd0));
    send_item(file_header(16'd1, AllOnes, 64'd0));
    send_item(file_header(16'hffff, 64'd0, AllOnes));
    send_item(file_header(16'd1, 64'd0, 64'd0));

    // image size shrinks while an image is open
    send_item(file_header(16'd4, 64'h40, 64'h1234));
    send_item(prog_header(32'h6474_e551, 64'd0, 64'd0, 64'd0, 64'd0));
    send_item(prog_header(SegLoad, 64'd0, 64'd0, 64'd0, AllOnes));
    send_item(prog_header(SegLoad, AllOnes, AllOnes, 64'd0, 64'd0));
    set_image_size(64'd64);
    send_item(prog_header(SegLoad, 64'd32, 64'h1000, 64'd33, 64'd33));
    send_item(file_header(16'd1, 64'd8, 64'd0));
    send_item(prog_header(SegLoad, 64'd0, 64'd0, 64'd2, 64'd1));
    send_item(file_header(16'd1, 64'd8, 64'd0));
    send_item(prog_header(SegLoad, 64'd0, AllOnes, 64'd0, 64'd1));
    send_item(file_header(16'd2, 64'd0, 64'd0));
    send_item(prog_header(32'd0, 64'd0, 64'd0, 64'd0, 64'd0));
    send_item(prog_header(32'hffff_ffff, 64'd0, 64'd0, 64'd0, 64'd0));

    run_phase(AllOnes, 250, 1'b1);
    run_phase(64'd4096, 200, 1'b1);
    hold_request = 1'b1;
    run_phase(64'h10_0000, 80, 1'b0);
    run_phase(64'd64, 120, 1'b1);
    run_phase(64'd63, 30, 1'b1);
    run_phase(rand64(), 220, 1'b1);
    run_phase({32'd0, $urandom}, 220, 1'b1);
    run_phase(64'd0, 20, 1'b1);
    run_phase(64'h8000_0000_0000_0000, 150, 1'b1);
    run_phase({40'd0, 24'($urandom)}, 260, 1'b0);

    idling = 1'b0;
    drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
